// File: hw/rtl/ggns_pkg.sv
`default_nettype none

package ggns_pkg;

  localparam int NUM_RATES      = 11;
  localparam int NUM_SPECIES    = 6;
  localparam int COUNT_BITS_DEF = 16;
  localparam int RATE_BITS_DEF  = 32;

  // item actions
  localparam logic [1:0] ACT_LOAD_RATE  = 2'd0;
  localparam logic [1:0] ACT_LOAD_COUNT = 2'd1;
  localparam logic [1:0] ACT_STEP       = 2'd2;

  // result status codes
  localparam logic [1:0] ST_FIRED  = 2'd0;
  localparam logic [1:0] ST_LOADED = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  // species numbers
  localparam logic [2:0] SP_D   = 3'd0;
  localparam logic [2:0] SP_R   = 3'd1;
  localparam logic [2:0] SP_A   = 3'd2;
  localparam logic [2:0] SP_B   = 3'd3;
  localparam logic [2:0] SP_AB  = 3'd4;
  localparam logic [2:0] SP_DAB = 3'd5;

  // reaction numbers
  localparam logic [3:0] RX_MK_R   = 4'd0;
  localparam logic [3:0] RX_MK_A   = 4'd1;
  localparam logic [3:0] RX_MK_B   = 4'd2;
  localparam logic [3:0] RX_BIND   = 4'd3;
  localparam logic [3:0] RX_UNBIND = 4'd4;
  localparam logic [3:0] RX_DBIND  = 4'd5;
  localparam logic [3:0] RX_DFREE  = 4'd6;
  localparam logic [3:0] RX_DG_R   = 4'd7;
  localparam logic [3:0] RX_DG_A   = 4'd8;
  localparam logic [3:0] RX_DG_B   = 4'd9;
  localparam logic [3:0] RX_DG_AB  = 4'd10;

  localparam logic [58:0] PROP_MAX = '1;
  localparam logic [31:0] LN2_Q29  = 32'd372130559;

  typedef enum logic [1:0] {
    EFF_NONE,
    EFF_INC,
    EFF_DEC
  } effect_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  index;
    logic [31:0] load_value;
    logic [31:0] u_time;
    logic [31:0] u_pick;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  reaction;
    logic [63:0] sim_time;
    logic [15:0] free_promoter;
    logic [15:0] mrna;
    logic [15:0] protein_a;
    logic [15:0] protein_b;
    logic [15:0] complex_ab;
    logic [15:0] bound_promoter;
  } out_item_t;

  // first count factor of a propensity term
  function automatic logic [2:0] first_species(input logic [3:0] rx);
    logic [2:0] s;
    case (rx)
      RX_MK_R:   s = SP_D;
      RX_MK_A:   s = SP_R;
      RX_MK_B:   s = SP_R;
      RX_BIND:   s = SP_A;
      RX_UNBIND: s = SP_AB;
      RX_DBIND:  s = SP_D;
      RX_DFREE:  s = SP_DAB;
      RX_DG_R:   s = SP_R;
      RX_DG_A:   s = SP_A;
      RX_DG_B:   s = SP_B;
      default:   s = SP_AB;
    endcase
    return s;
  endfunction

  // second count factor, for the two-reactant terms
  function automatic logic [2:0] second_species(input logic [3:0] rx);
    return (rx == RX_BIND) ? SP_B : SP_AB;
  endfunction

  function automatic logic has_two(input logic [3:0] rx);
    return (rx == RX_BIND) || (rx == RX_DBIND);
  endfunction

  // change of one species when a reaction fires
  function automatic effect_e effect_of(input logic [3:0] rx, input logic [2:0] sp);
    effect_e e;
    e = EFF_NONE;
    case (rx)
      RX_MK_R:   if (sp == SP_R) e = EFF_INC;
      RX_MK_A:   if (sp == SP_A) e = EFF_INC;
      RX_MK_B:   if (sp == SP_B) e = EFF_INC;
      RX_BIND: begin
        if (sp == SP_A || sp == SP_B) e = EFF_DEC;
        if (sp == SP_AB) e = EFF_INC;
      end
      RX_UNBIND: begin
        if (sp == SP_A || sp == SP_B) e = EFF_INC;
        if (sp == SP_AB) e = EFF_DEC;
      end
      RX_DBIND: begin
        if (sp == SP_D || sp == SP_AB) e = EFF_DEC;
        if (sp == SP_DAB) e = EFF_INC;
      end
      RX_DFREE: begin
        if (sp == SP_D || sp == SP_AB) e = EFF_INC;
        if (sp == SP_DAB) e = EFF_DEC;
      end
      RX_DG_R:   if (sp == SP_R) e = EFF_DEC;
      RX_DG_A:   if (sp == SP_A) e = EFF_DEC;
      RX_DG_B:   if (sp == SP_B) e = EFF_DEC;
      RX_DG_AB:  if (sp == SP_AB) e = EFF_DEC;
      default:   e = EFF_NONE;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gillespie_gene_network_step.sv
`default_nettype none
// channel  | dir | handshake                | payload
// in       | in  | in_valid_i / in_stall_o  | in_data_i  (in_item_t)
// out      | out | out_valid_o / out_stall_i| out_data_o (out_item_t)
//
// loads and idle actions present their result the cycle after the transfer;
// a step runs from transfer to result through these phases: the terms
// (single-factor and two-factor) on the shared 32x32 multiplier,
// the pick product, the pick compares, normalize, log squarings,
// scaling, divider start, the bit-serial divider, and presenting.
// rates, counts and time clear on reset; no clearing pass.
// a held result blocks the next transfer only while out_stall_i is high.

module gillespie_gene_network_step #(
  parameter int COUNT_BITS = ggns_pkg::COUNT_BITS_DEF,
  parameter int RATE_BITS  = ggns_pkg::RATE_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ggns_pkg::in_item_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ggns_pkg::out_item_t     out_data_o
);
  import ggns_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PMUL    = 4'd1;
  localparam logic [3:0] S_PICKMUL = 4'd2;
  localparam logic [3:0] S_PICK    = 4'd3;
  localparam logic [3:0] S_NORM    = 4'd4;
  localparam logic [3:0] S_SQ      = 4'd5;
  localparam logic [3:0] S_LNMUL   = 4'd6;
  localparam logic [3:0] S_DIVGO   = 4'd7;
  localparam logic [3:0] S_DIV     = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]            state_q, state_d;
  logic [RATE_BITS-1:0]  rate_q [NUM_RATES];
  logic [RATE_BITS-1:0]  rate_d [NUM_RATES];
  logic [COUNT_BITS-1:0] cnt_q [NUM_SPECIES];
  logic [COUNT_BITS-1:0] cnt_d [NUM_SPECIES];
  logic [63:0]           time_q, time_d;
  logic [58:0]           prop_q [NUM_RATES];
  logic                  prop_we;
  logic [3:0]            term_q, term_d;
  logic [1:0]            ph_q, ph_d;
  logic                  second_q, second_d;
  logic [63:0]           opa_q, opa_d;
  logic [95:0]           acc_q, acc_d;
  logic [63:0]           total_q, total_d;
  logic [63:0]           cum_q, cum_d;
  logic [31:0]           upick_q, upick_d;
  logic [31:0]           m_q, m_d;
  logic [4:0]            sh_q, sh_d;
  logic [29:0]           frac_q, frac_d;
  logic [3:0]            sel_q, sel_d;
  logic [1:0]            st_q, st_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  logic        in_xfer, out_free, out_load;
  logic [1:0]  res_status;
  logic [3:0]  res_rxn;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;
  logic [58:0] sat;
  logic [63:0] total_n, cum_n;
  logic [5:0]  amt;
  logic [31:0] m_sh, sq32;
  logic [35:0] neg;
  logic [64:0] sum65;
  logic        div_start, div_done;
  logic [63:0] div_quo;
  logic [31:0] c32 [NUM_SPECIES];
  effect_e     eff;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign neg        = {6'(sh_q) + 6'd1, 30'd0} - 36'(frac_q);
  assign div_start  = (state_q == S_DIVGO);

  // shared multiplier operand select
  always_comb begin
    mul_x = opa_q[31:0];
    mul_y = '0;
    case (state_q)
      S_PMUL: begin
        mul_x = (ph_q == 2'd0) ? opa_q[31:0] : opa_q[63:32];
        mul_y = second_q ? 32'(cnt_q[second_species(term_q)])
                         : 32'(cnt_q[first_species(term_q)]);
      end
      S_PICKMUL: begin
        mul_x = (ph_q == 2'd0) ? opa_q[31:0] : opa_q[63:32];
        mul_y = upick_q;
      end
      S_SQ: begin
        mul_x = m_q;
        mul_y = m_q;
      end
      S_LNMUL: begin
        mul_x = (ph_q == 2'd0) ? neg[31:0] : 32'(neg[35:32]);
        mul_y = LN2_Q29;
      end
      default: mul_y = '0;
    endcase
  end

  assign mul_p = mul_x * mul_y;

  ggns_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({acc_q[74:29], 18'd0}),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    rate_d     = rate_q;
    cnt_d      = cnt_q;
    time_d     = time_q;
    term_d     = term_q;
    ph_d       = ph_q;
    second_d   = second_q;
    opa_d      = opa_q;
    acc_d      = acc_q;
    total_d    = total_q;
    cum_d      = cum_q;
    upick_d    = upick_q;
    m_d        = m_q;
    sh_d       = sh_q;
    frac_d     = frac_q;
    sel_d      = sel_q;
    st_d       = st_q;
    prop_we    = 1'b0;
    out_load   = 1'b0;
    res_status = ST_LOADED;
    res_rxn    = '0;
    sat        = (|acc_q[95:59]) ? PROP_MAX : acc_q[58:0];
    total_n    = total_q + 64'(sat);
    cum_n      = cum_q + 64'(prop_q[term_q]);
    m_sh       = m_q;
    sq32       = mul_p[61:30];
    sum65      = {1'b0, time_q} + {1'b0, div_quo};
    eff        = EFF_NONE;
    amt        = 6'd16 >> term_q[2:0];

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_data_i.action)
            ACT_LOAD_RATE: begin
              if (in_data_i.index < 4'(NUM_RATES)) begin
                rate_d[in_data_i.index] = RATE_BITS'(in_data_i.load_value);
              end
              out_load = 1'b1;
            end
            ACT_LOAD_COUNT: begin
              out_load = 1'b1;
              if (in_data_i.index < 4'(NUM_SPECIES)) begin
                if (in_data_i.load_value > 32'(CNT_MAX)) begin
                  cnt_d[in_data_i.index[2:0]] = CNT_MAX;
                  res_status = ST_SAT;
                end else begin
                  cnt_d[in_data_i.index[2:0]] = COUNT_BITS'(in_data_i.load_value);
                end
              end
            end
            ACT_STEP: begin
              term_d   = '0;
              ph_d     = '0;
              second_d = 1'b0;
              total_d  = '0;
              opa_d    = 64'(rate_q[0]);
              upick_d  = in_data_i.u_pick;
              m_d      = (in_data_i.u_time == '0) ? 32'd1 : in_data_i.u_time;
              state_d  = S_PMUL;
            end
            default: out_load = 1'b1;
          endcase
        end
      end

      // propensity terms: 64x32 product in two halves, then saturate
      S_PMUL: begin
        case (ph_q)
          2'd0: begin
            acc_d = {32'd0, mul_p};
            ph_d  = 2'd1;
          end
          2'd1: begin
            acc_d = acc_q + {mul_p, 32'd0};
            ph_d  = 2'd2;
          end
          default: begin
            ph_d = 2'd0;
            if (has_two(term_q) && !second_q) begin
              opa_d    = 64'(sat);
              second_d = 1'b1;
            end else begin
              prop_we  = 1'b1;
              total_d  = total_n;
              second_d = 1'b0;
              if (term_q == RX_DG_AB) begin
                if (total_n == '0) begin
                  st_d    = ST_ZERO;
                  sel_d   = '0;
                  state_d = S_DONE;
                end else begin
                  opa_d   = total_n;
                  state_d = S_PICKMUL;
                end
              end else begin
                term_d = term_q + 4'd1;
                opa_d  = 64'(rate_q[term_q + 4'd1]);
              end
            end
          end
        endcase
      end

      // target = u_pick * total
      S_PICKMUL: begin
        if (ph_q == 2'd0) begin
          acc_d = {32'd0, mul_p};
          ph_d  = 2'd1;
        end else begin
          acc_d   = acc_q + {mul_p, 32'd0};
          ph_d    = 2'd0;
          term_d  = '0;
          cum_d   = '0;
          state_d = S_PICK;
        end
      end

      // running sum compare, one term per cycle
      S_PICK: begin
        cum_d = cum_n;
        if (acc_q < {cum_n, 32'd0}) begin
          sel_d   = term_q;
          sh_d    = '0;
          term_d  = '0;
          state_d = S_NORM;
        end else if (term_q == RX_DG_B) begin
          sel_d   = RX_DG_AB;
          sh_d    = '0;
          term_d  = '0;
          state_d = S_NORM;
        end else begin
          term_d = term_q + 4'd1;
        end
      end

      // normalize u_time in five binary steps (term counts the step)
      S_NORM: begin
        if ((m_q >> (6'd32 - amt)) == '0) begin
          m_sh = m_q << amt;
          sh_d = sh_q + 5'(amt);
        end
        m_d    = m_sh;
        term_d = term_q + 4'd1;
        if (term_q == 4'd4) begin
          m_d     = m_sh >> 1;
          ph_d    = '0;
          term_d  = '0;
          state_d = S_SQ;
        end
      end

      // log2 fraction by repeated squaring
      S_SQ: begin
        m_d    = sq32[31] ? (sq32 >> 1) : sq32;
        frac_d = {frac_q[28:0], sq32[31]};
        term_d = term_q + 4'd1;
        if (term_q == 4'd15) begin
          term_d = '0;
          if (ph_q == 2'd1) begin
            state_d = S_LNMUL;
            ph_d    = '0;
          end else begin
            ph_d = ph_q + 2'd1;
          end
        end else if (term_q == 4'd12 && ph_q == 2'd1) begin
          term_d = 4'd15;
        end
      end

      // ln = neg * ln2
      S_LNMUL: begin
        if (ph_q == 2'd0) begin
          acc_d = {32'd0, mul_p};
          ph_d  = 2'd1;
        end else begin
          acc_d   = acc_q + {mul_p, 32'd0};
          ph_d    = 2'd0;
          state_d = S_DIVGO;
        end
      end

      S_DIVGO: state_d = S_DIV;

      // apply time and reaction effects
      S_DIV: begin
        if (div_done) begin
          time_d = sum65[64] ? '1 : sum65[63:0];
          st_d   = ST_FIRED;
          for (int s = 0; s < NUM_SPECIES; s++) begin
            eff = effect_of(sel_q, 3'(s));
            if (eff == EFF_INC) begin
              if (cnt_q[s] == CNT_MAX) begin
                st_d = ST_SAT;
              end else begin
                cnt_d[s] = cnt_q[s] + 1'b1;
              end
            end else if (eff == EFF_DEC) begin
              if (cnt_q[s] == '0) begin
                st_d = ST_SAT;
              end else begin
                cnt_d[s] = cnt_q[s] - 1'b1;
              end
            end
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        res_status = st_q;
        res_rxn    = sel_q;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // result packing from next-state values
  always_comb begin
    for (int s = 0; s < NUM_SPECIES; s++) begin
      c32[s] = 32'(cnt_d[s]);
    end
    out_d                = out_q;
    out_valid_d          = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (out_load) begin
      out_valid_d           = 1'b1;
      out_d.status          = res_status;
      out_d.reaction        = res_rxn;
      out_d.sim_time        = time_d;
      out_d.free_promoter   = c32[SP_D][15:0];
      out_d.mrna            = c32[SP_R][15:0];
      out_d.protein_a       = c32[SP_A][15:0];
      out_d.protein_b       = c32[SP_B][15:0];
      out_d.complex_ab      = c32[SP_AB][15:0];
      out_d.bound_promoter  = c32[SP_DAB][15:0];
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      time_q      <= '0;
      for (int i = 0; i < NUM_RATES; i++) rate_q[i] <= '0;
      for (int s = 0; s < NUM_SPECIES; s++) cnt_q[s] <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      time_q      <= time_d;
      rate_q      <= rate_d;
      cnt_q       <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    term_q   <= term_d;
    ph_q     <= ph_d;
    second_q <= second_d;
    opa_q    <= opa_d;
    acc_q    <= acc_d;
    total_q  <= total_d;
    cum_q    <= cum_d;
    upick_q  <= upick_d;
    m_q      <= m_d;
    sh_q     <= sh_d;
    frac_q   <= frac_d;
    sel_q    <= sel_d;
    st_q     <= st_d;
    out_q    <= out_d;
    if (prop_we) prop_q[term_q] <= sat;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/ggns_div.sv
`default_nettype none

module ggns_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [63:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] dvs_q, dvs_d;
  logic [64:0] rem_sh;
  logic        ge;

  // one restoring step per cycle, quotient shifts in behind the dividend
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q, quo_q[63]};
    ge     = rem_sh >= {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? 64'(rem_sh - {1'b0, dvs_q}) : rem_sh[63:0];
      quo_d = {quo_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/ggns_chk.sv
`default_nettype none

module ggns_chk (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire ggns_pkg::in_item_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire ggns_pkg::out_item_t out_data_o
);
  import ggns_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // a blocked output blocks the input
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken with result held");

  // rate loads answer at once
  a_load_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_data_i.action == ACT_LOAD_RATE |=>
      out_valid_o && out_data_o.status == ST_LOADED && out_data_o.reaction == 4'd0)
    else $error("rate load result wrong");

  // a step never answers in the next cycle
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_data_i.action == ACT_STEP |=> !out_valid_o)
    else $error("step result too early");

endmodule

bind gillespie_gene_network_step ggns_chk u_ggns_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// File: verif/gillespie_gene_network_step_checker.sv
`default_nettype none

module gillespie_gene_network_step_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire ggns_pkg::in_item_t in_data_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire ggns_pkg::out_item_t out_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ggns_pkg::*;

  localparam logic [63:0] TERM_CAP  = 64'h07FF_FFFF_FFFF_FFFF;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;

  // model state of the network
  logic [31:0] rate_q [NUM_RATES];
  logic [15:0] count_q [NUM_SPECIES];
  logic [63:0] clock_acc;

  out_item_t awaited_states [$];

  // rate times count, clipped to the per-term ceiling
  function automatic logic [63:0] capped_product(logic [63:0] x, logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return (p > {64'd0, TERM_CAP}) ? TERM_CAP : p[63:0];
  endfunction

  // -ln(u/2^32) in Q.30 from a bitwise log2
  function automatic logic [63:0] wait_log(logic [31:0] u);
    logic [63:0] uu, m, frac, nl;
    int p;
    uu = (u == 0) ? 64'd1 : {32'd0, u};
    p = 0;
    frac = 0;
    while (p < 31 && (uu >> (p + 1)) != 0) p++;
    m = (p >= 30) ? (uu >> (p - 30)) : (uu << (30 - p));
    for (int k = 0; k < 30; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    nl = (64'd32 << 30) - ((64'(p) << 30) + frac);
    return (nl * 64'(LN2_Q29)) >> 29;
  endfunction

  // count change of species sp when reaction rx fires
  function automatic int count_delta(int rx, int sp);
    int dl;
    dl = 0;
    case (rx)
      0:  if (sp == 1) dl = 1;
      1:  if (sp == 2) dl = 1;
      2:  if (sp == 3) dl = 1;
      3:  dl = (sp == 2 || sp == 3) ? -1 : (sp == 4) ? 1 : 0;
      4:  dl = (sp == 2 || sp == 3) ? 1 : (sp == 4) ? -1 : 0;
      5:  dl = (sp == 0 || sp == 4) ? -1 : (sp == 5) ? 1 : 0;
      6:  dl = (sp == 0 || sp == 4) ? 1 : (sp == 5) ? -1 : 0;
      7:  if (sp == 1) dl = -1;
      8:  if (sp == 2) dl = -1;
      9:  if (sp == 3) dl = -1;
      default: if (sp == 4) dl = -1;
    endcase
    return dl;
  endfunction

  // apply one item to the model and form the result it causes
  function automatic out_item_t advance_network(in_item_t it);
    out_item_t res;
    logic [63:0] prop [NUM_RATES];
    logic [63:0] total, cum, dt;
    logic [95:0] target;
    logic [1:0] st;
    int sel, dl;
    logic found;
    st = ST_LOADED;
    sel = 0;
    if (it.action == ACT_LOAD_RATE) begin
      if (it.index < NUM_RATES) rate_q[it.index] = it.load_value;
    end else if (it.action == ACT_LOAD_COUNT) begin
      if (it.index < NUM_SPECIES) begin
        if (it.load_value > 32'(COUNT_TOP)) begin
          count_q[it.index] = COUNT_TOP;
          st = ST_SAT;
        end else begin
          count_q[it.index] = it.load_value[15:0];
        end
      end
    end else if (it.action == ACT_STEP) begin
      prop[0]  = capped_product(rate_q[0], count_q[0]);
      prop[1]  = capped_product(rate_q[1], count_q[1]);
      prop[2]  = capped_product(rate_q[2], count_q[1]);
      prop[3]  = capped_product(capped_product(rate_q[3], count_q[2]), count_q[3]);
      prop[4]  = capped_product(rate_q[4], count_q[4]);
      prop[5]  = capped_product(capped_product(rate_q[5], count_q[0]), count_q[4]);
      prop[6]  = capped_product(rate_q[6], count_q[5]);
      prop[7]  = capped_product(rate_q[7], count_q[1]);
      prop[8]  = capped_product(rate_q[8], count_q[2]);
      prop[9]  = capped_product(rate_q[9], count_q[3]);
      prop[10] = capped_product(rate_q[10], count_q[4]);
      total = 0;
      for (int i = 0; i < NUM_RATES; i++) total += prop[i];
      if (total == 0) begin
        st = ST_ZERO;
      end else begin
        st = ST_FIRED;
        // first running sum above pick times total
        target = {64'd0, it.u_pick} * {32'd0, total};
        cum = 0;
        sel = NUM_RATES - 1;
        found = 1'b0;
        for (int i = 0; i < NUM_RATES - 1; i++) begin
          cum += prop[i];
          if (!found && target < {cum, 32'd0}) begin
            sel = i;
            found = 1'b1;
          end
        end
        dt = (wait_log(it.u_time) << 18) / total;
        clock_acc = (clock_acc > ~dt) ? '1 : clock_acc + dt;
        // species updates with clamping at both ends
        for (int s = 0; s < NUM_SPECIES; s++) begin
          dl = count_delta(sel, s);
          if (dl > 0) begin
            if (count_q[s] == COUNT_TOP) st = ST_SAT;
            else count_q[s] = count_q[s] + 16'd1;
          end else if (dl < 0) begin
            if (count_q[s] == 0) st = ST_SAT;
            else count_q[s] = count_q[s] - 16'd1;
          end
        end
      end
    end
    res.status         = st;
    res.reaction       = 4'(sel);
    res.sim_time       = clock_acc;
    res.free_promoter  = count_q[0];
    res.mrna           = count_q[1];
    res.protein_a      = count_q[2];
    res.protein_b      = count_q[3];
    res.complex_ab     = count_q[4];
    res.bound_promoter = count_q[5];
    return res;
  endfunction

  assign pending_o = awaited_states.size();

  // predict on input transfer, compare on output transfer
  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      clock_acc = 0;
      for (int i = 0; i < NUM_RATES; i++) rate_q[i] = 0;
      for (int i = 0; i < NUM_SPECIES; i++) count_q[i] = 0;
    end else begin
      if (in_valid_i && !in_stall_i) awaited_states.push_back(advance_network(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (awaited_states.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result %h", out_data_i);
        end else begin
          want = awaited_states.pop_front();
          if (out_data_i !== want) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display({"mismatch st %0d/%0d rx %0d/%0d t %h/%h ",
                        "cnt %h %h %h %h %h %h / %h %h %h %h %h %h"},
                       want.status, out_data_i.status, want.reaction, out_data_i.reaction,
                       want.sim_time, out_data_i.sim_time,
                       want.free_promoter, want.mrna, want.protein_a, want.protein_b,
                       want.complex_ab, want.bound_promoter,
                       out_data_i.free_promoter, out_data_i.mrna, out_data_i.protein_a,
                       out_data_i.protein_b, out_data_i.complex_ab,
                       out_data_i.bound_promoter);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: verif/gillespie_gene_network_step_tb.sv
`default_nettype none

module gillespie_gene_network_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ggns_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int IDLE_LIMIT   = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  gillespie_gene_network_step DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  gillespie_gene_network_step_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // idle lengths: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // offer one item and hold it until the transfer
  task automatic offer(logic [1:0] act, logic [3:0] idx, logic [31:0] val,
                       logic [31:0] ut, logic [31:0] up, logic quiet);
    int g;
    g = quiet ? 0 : pick_gap();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_data = '{action: act, index: idx, load_value: val, u_time: ut, u_pick: up};
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // receiver stalls, with one long hold-off
  initial begin
    int burst, cyc;
    burst = 0;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc == 15000) burst = 800;
      if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if ((cyc / 3000) % 4 == 3) begin
        out_stall = 1'b0;
      end else begin
        burst = pick_gap();
        out_stall = (burst > 0);
        if (burst > 0) burst--;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("gillespie_gene_network_step_tb failed");
        $finish;
      end
    end
  end

  initial begin
    int r, n;
    logic quiet;
    logic [31:0] v;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty network, odd actions, bad indexes, saturation
    offer(ACT_STEP, 4'd0, 32'd0, 32'd1, 32'd0, 1'b0);
    offer(2'd3, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    offer(ACT_LOAD_RATE, 4'd15, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
    offer(ACT_LOAD_COUNT, 4'd15, 32'd5, 32'd0, 32'd0, 1'b0);
    offer(ACT_LOAD_COUNT, 4'd0, 32'h0001_0000, 32'd0, 32'd0, 1'b0);
    for (int i = 0; i < NUM_RATES; i++)
      offer(ACT_LOAD_RATE, 4'(i), 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
    for (int i = 1; i < NUM_SPECIES; i++)
      offer(ACT_LOAD_COUNT, 4'(i), 32'h0000_FFFF, 32'd0, 32'd0, 1'b0);
    offer(ACT_STEP, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    offer(ACT_STEP, 4'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    offer(ACT_STEP, 4'd0, 32'd0, 32'd1, 32'h8000_0000, 1'b0);

    // random mix of loads and steps
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = ((n / 150) % 4 == 2);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        r = $urandom_range(0, 19);
        v = (r < 1) ? 32'd0 : (r < 3) ? $urandom : $urandom_range(0, 32'h0004_0000);
        offer(ACT_LOAD_RATE, ($urandom_range(0, 9) == 0) ? 4'($urandom) :
              4'($urandom_range(0, 10)), v, $urandom, $urandom, quiet);
      end else if (r < 24) begin
        r = $urandom_range(0, 19);
        v = (r < 2) ? $urandom : (r < 4) ? $urandom_range(65530, 65535) :
            $urandom_range(0, 30);
        offer(ACT_LOAD_COUNT, ($urandom_range(0, 9) == 0) ? 4'($urandom) :
              4'($urandom_range(0, 5)), v, $urandom, $urandom, quiet);
      end else if (r < 96) begin
        r = $urandom_range(0, 49);
        v = (r == 0) ? 32'd0 : (r == 1) ? 32'd1 : $urandom;
        offer(ACT_STEP, 4'($urandom), $urandom, v, $urandom, quiet);
      end else begin
        offer(2'd3, 4'($urandom), $urandom, $urandom, $urandom, quiet);
      end
    end
    in_valid = 1'b0;

    // drain, then a short tail
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("gillespie_gene_network_step_tb passed");
    else $display("gillespie_gene_network_step_tb failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: gillespie_gene_network_step.f
hw/rtl/ggns_pkg.sv
hw/rtl/ggns_div.sv
hw/rtl/gillespie_gene_network_step.sv
hw/rtl/ggns_chk.sv
verif/gillespie_gene_network_step_checker.sv
verif/gillespie_gene_network_step_tb.sv
